>>> hdl/wall_vdw_retarded_force_unit_macros.svh
// assertion macros shared by the retarded van der Waals wall force unit
// expects signals clk and rst_n in the scope of use
`ifndef WALL_VDW_RETARDED_FORCE_UNIT_MACROS_SVH
`define WALL_VDW_RETARDED_FORCE_UNIT_MACROS_SVH

// condition must never hold outside reset
`define WVDW_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// consequent must hold in the same cycle as the antecedent
`define WVDW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

>>> hdl/wvdw_pkg.sv
// shared types and constants of the retarded van der Waals wall force unit
// no dependencies
package wvdw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WALL_FACE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_POSITION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETARD_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETARD_LAMBDA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEPARATION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HAMAKER        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF         = 3'd7;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [30:0] ONE_Q16 = 31'd65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam int NUM_W      = 126;
    localparam int DEN_W      = 129;
    localparam int QUO_W      = 32;
    localparam int DIV_CMP_W  = DEN_W + QUO_W;

    localparam logic [31:0] LIMIT_LO = 32'h8000_0000;
    localparam logic [31:0] LIMIT_HI = 32'h7FFF_FFFF;

    typedef struct packed {
        logic       active;
        logic       side;
        logic [1:0] axis;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [30:0] sep_clamp;
        logic [31:0] reff2;
    } work_t;

    typedef struct packed {
        logic [30:0] hamaker;
        logic [30:0] lambda;
        logic [30:0] b;
    } coef_t;

endpackage

>>> hdl/wvdw_front.sv
// front end: accepts particles, measures wall distance, band test and clamp
// depends on wvdw_pkg
module wvdw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic [30:0]          particle_radius,
    input  logic                 in_group,
    input  logic [2:0]           wall_face,
    input  logic signed [31:0]   wall_position,
    input  logic                 radius_mode,
    input  logic [30:0]          min_separation,
    input  logic [30:0]          cutoff,
    input  logic                 queue_full,
    output logic                 push,
    output wvdw_pkg::work_t      push_item
);
    import wvdw_pkg::*;

    logic               front_en;
    logic               f1_valid_reg;
    logic               f2_valid_reg;
    meta_t              f1_meta_reg;
    meta_t              f2_meta_reg;
    meta_t              meta_next;
    logic signed [32:0] f1_dist_reg;
    logic signed [32:0] dist_next;
    logic [30:0]        f1_size_reg;
    logic [30:0]        f2_size_reg;
    logic [31:0]        f1_reff2_reg;
    logic [31:0]        f2_reff2_reg;
    logic               f1_mode_reg;
    logic               f2_mode_reg;
    logic signed [31:0] pos_sel;
    logic [32:0]        abs_dist;
    logic signed [33:0] sep_next;
    logic signed [33:0] f2_sep_reg;
    logic [33:0]        abs_sep;
    logic               band;
    logic               sep_lt_min;

    always_comb
    begin
        case (wall_face[2:1])
            AXIS_X:  pos_sel = pos_x;
            AXIS_Y:  pos_sel = pos_y;
            AXIS_Z:  pos_sel = pos_z;
            default: pos_sel = pos_x;
        endcase
    end

    assign meta_next.active = in_group && (wall_face[2:1] != AXIS_NONE);
    assign meta_next.side   = wall_face[0];
    assign meta_next.axis   = wall_face[2:1];

    // lo wall: particle minus wall, hi wall: wall minus particle
    assign dist_next = wall_face[0]
        ? ($signed({wall_position[31], wall_position}) - $signed({pos_sel[31], pos_sel}))
        : ($signed({pos_sel[31], pos_sel}) - $signed({wall_position[31], wall_position}));

    assign abs_dist = f1_dist_reg[32] ? 33'(-f1_dist_reg) : 33'(f1_dist_reg);
    assign sep_next = $signed({1'b0, abs_dist}) - $signed({3'b000, f1_size_reg});

    assign abs_sep = f2_sep_reg[33] ? 34'(-f2_sep_reg) : 34'(f2_sep_reg);
    assign band = f2_mode_reg ? ({1'b0, abs_sep, 1'b0} < {5'b0, f2_size_reg})
                              : ({abs_sep, 2'b00} < {5'b0, f2_size_reg});
    assign sep_lt_min = f2_sep_reg < $signed({3'b000, min_separation});

    assign push_item.meta.active = f2_meta_reg.active && band;
    assign push_item.meta.side   = f2_meta_reg.side;
    assign push_item.meta.axis   = f2_meta_reg.axis;
    assign push_item.sep_clamp   = sep_lt_min ? min_separation : f2_sep_reg[30:0];
    assign push_item.reff2       = f2_reff2_reg;

    assign front_en = !f2_valid_reg || !queue_full;
    assign push     = f2_valid_reg && !queue_full;
    assign in_stall = !front_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f1_meta_reg  <= meta_next;
            f1_dist_reg  <= dist_next;
            f1_size_reg  <= radius_mode ? particle_radius : cutoff;
            f1_reff2_reg <= radius_mode ? {particle_radius, 1'b0} : {1'b0, cutoff};
            f1_mode_reg  <= radius_mode;
            f2_meta_reg  <= f1_meta_reg;
            f2_sep_reg   <= sep_next;
            f2_size_reg  <= f1_size_reg;
            f2_reff2_reg <= f1_reff2_reg;
            f2_mode_reg  <= f1_mode_reg;
        end
    end

endmodule

>>> hdl/wvdw_fifo.sv
// short queue between the classifying front and the arithmetic back
// depends on wvdw_pkg and the assertion macro header
`include "wall_vdw_retarded_force_unit_macros.svh"

module wvdw_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wvdw_pkg::work_t push_item,
    input  logic            pop,
    output wvdw_pkg::work_t pop_item,
    output logic            full,
    output logic            empty
);
    import wvdw_pkg::*;

    work_t               slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full     = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    `WVDW_ASSERT_NEVER(a_no_overflow, push && full && !pop)
    `WVDW_ASSERT_NEVER(a_no_underflow, pop && empty)
    `WVDW_ASSERT_IMPLIES(a_ptr_gap, !full && !empty, (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])

endmodule

>>> hdl/wvdw_mul.sv
// back end multiply stages: numerator and denominator of the force quotient
// depends on wvdw_pkg
module wvdw_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  wvdw_pkg::work_t      in_item,
    input  wvdw_pkg::coef_t      coef,
    output logic                 out_valid,
    output wvdw_pkg::meta_t      out_meta,
    output logic [wvdw_pkg::NUM_W-1:0] out_num,
    output logic [wvdw_pkg::DEN_W-1:0] out_den
);
    import wvdw_pkg::*;

    logic        m1_valid_reg, m2_valid_reg, m3_valid_reg, m4_valid_reg;
    meta_t       m1_meta_reg, m2_meta_reg, m3_meta_reg, m4_meta_reg;
    logic [62:0] m1_hr_reg;
    logic [61:0] m1_ss_reg;
    logic [61:0] m1_bs_reg;
    logic [62:0] m2_lam_lo_reg;
    logic [61:0] m2_lam_hi_reg;
    logic [62:0] m2_t_reg;
    logic [65:0] m2_s12_reg;
    logic [93:0] m3_num_reg;
    logic [63:0] m3_pp00_reg;
    logic [62:0] m3_pp01_reg;
    logic [63:0] m3_pp10_reg;
    logic [62:0] m3_pp11_reg;
    logic [33:0] m3_pp20_reg;
    logic [32:0] m3_pp21_reg;
    logic [NUM_W-1:0] m4_num_reg;
    logic [DEN_W-1:0] m4_den_reg;
    logic [DEN_W-1:0] den_next;

    // 12 * s^2 * (b*s + lambda*2^16) from six 32-bit partial products
    assign den_next = DEN_W'(m3_pp00_reg)
                    + (DEN_W'(m3_pp01_reg) << 32) + (DEN_W'(m3_pp10_reg) << 32)
                    + (DEN_W'(m3_pp11_reg) << 64) + (DEN_W'(m3_pp20_reg) << 64)
                    + (DEN_W'(m3_pp21_reg) << 96);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_meta_reg   <= in_item.meta;
            m1_hr_reg     <= 63'(coef.hamaker) * 63'(in_item.reff2);
            m1_ss_reg     <= 62'(in_item.sep_clamp) * 62'(in_item.sep_clamp);
            m1_bs_reg     <= 62'(coef.b) * 62'(in_item.sep_clamp);

            m2_meta_reg   <= m1_meta_reg;
            m2_lam_lo_reg <= 63'(m1_hr_reg[31:0]) * 63'(coef.lambda);
            m2_lam_hi_reg <= 62'(m1_hr_reg[62:32]) * 62'(coef.lambda);
            m2_t_reg      <= 63'(m1_bs_reg) + (63'(coef.lambda) << 16);
            m2_s12_reg    <= (66'(m1_ss_reg) << 3) + (66'(m1_ss_reg) << 2);

            m3_meta_reg   <= m2_meta_reg;
            m3_num_reg    <= (94'(m2_lam_hi_reg) << 32) + 94'(m2_lam_lo_reg);
            m3_pp00_reg   <= 64'(m2_s12_reg[31:0]) * 64'(m2_t_reg[31:0]);
            m3_pp01_reg   <= 63'(m2_s12_reg[31:0]) * 63'(m2_t_reg[62:32]);
            m3_pp10_reg   <= 64'(m2_s12_reg[63:32]) * 64'(m2_t_reg[31:0]);
            m3_pp11_reg   <= 63'(m2_s12_reg[63:32]) * 63'(m2_t_reg[62:32]);
            m3_pp20_reg   <= 34'(m2_s12_reg[65:64]) * 34'(m2_t_reg[31:0]);
            m3_pp21_reg   <= 33'(m2_s12_reg[65:64]) * 33'(m2_t_reg[62:32]);

            m4_meta_reg   <= m3_meta_reg;
            m4_num_reg    <= {m3_num_reg, 32'b0};
            m4_den_reg    <= den_next;
        end
    end

    assign out_valid = m4_valid_reg;
    assign out_meta  = m4_meta_reg;
    assign out_num   = m4_num_reg;
    assign out_den   = m4_den_reg;

endmodule

>>> hdl/wvdw_div.sv
// back end divider: overflow check, then one quotient bit per stage
// depends on wvdw_pkg
module wvdw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  wvdw_pkg::meta_t             in_meta,
    input  logic [wvdw_pkg::NUM_W-1:0]  in_num,
    input  logic [wvdw_pkg::DEN_W-1:0]  in_den,
    output logic                        out_valid,
    output wvdw_pkg::meta_t             out_meta,
    output logic [wvdw_pkg::QUO_W-1:0]  out_quo,
    output logic                        out_big
);
    import wvdw_pkg::*;

    logic [QUO_W:0]   valid_reg;
    meta_t            meta_reg [QUO_W+1];
    logic [NUM_W-1:0] rem_reg  [QUO_W+1];
    logic [DEN_W-1:0] den_reg  [QUO_W+1];
    logic [QUO_W-1:0] quo_reg  [QUO_W+1];
    logic             big_reg  [QUO_W+1];
    logic             big_next;

    // quotient of 2^32 or more, or nonzero over zero: saturates
    assign big_next = (DIV_CMP_W'(in_num) >= (DIV_CMP_W'(in_den) << QUO_W))
                   && (in_num != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= in_meta;
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            big_reg[0]  <= big_next;
        end
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - g;
        logic [DIV_CMP_W-1:0] den_sh;
        logic [DIV_CMP_W-1:0] diff;
        logic                 fits;

        // zero over zero keeps a zero quotient
        assign den_sh = DIV_CMP_W'(den_reg[g]) << BIT;
        assign fits   = (DIV_CMP_W'(rem_reg[g]) >= den_sh) && (den_reg[g] != '0);
        assign diff   = DIV_CMP_W'(rem_reg[g]) - den_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[g+1] <= meta_reg[g];
                den_reg[g+1]  <= den_reg[g];
                big_reg[g+1]  <= big_reg[g];
                rem_reg[g+1]  <= fits ? diff[NUM_W-1:0] : rem_reg[g];
                quo_reg[g+1]  <= fits ? (quo_reg[g] | (QUO_W'(1) << BIT)) : quo_reg[g];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_meta  = meta_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_big   = big_reg[QUO_W];

endmodule

>>> hdl/wall_vdw_retarded_force_unit.sv
// top level of the retarded van der Waals wall force unit
// depends on wvdw_pkg, wvdw_front, wvdw_fifo, wvdw_mul, wvdw_div and the macro header
`include "wall_vdw_retarded_force_unit_macros.svh"

// One particle in, one force increment out, one item per clock cycle when unstalled.
// The front end (two stages) takes the particle, finds its signed distance to
// the wall chosen by wall_face, subtracts the radius or the cutoff, applies the
// band test and clamps the separation at min_separation; the item then waits
// in a four-entry queue. The back end forms Ha*2Reff*lambda*2^32 and
// 12*s^2*(b*s + lambda*2^16) in four multiply stages built from 32-bit
// partial products, then a pipelined restoring divider gives one quotient bit
// per stage after an overflow check, so the divider sets the depth (an item
// passes two front stages, the queue, four multiply stages, 33 divider
// stages and the output register). The force is -M on a lo wall and +M on a
// hi wall along the wall normal, saturated to the Q16.16 range with the
// saturated flag raised. Items outside the group, out of band or with face
// six or seven give an all-zero result. The whole back end holds while a
// finished result is stalled at the output register; the queue keeps the
// front taking items meanwhile until it is full.
// Configuration is written through cfg_write/cfg_index/cfg_data and must only
// change while the unit is idle.
module wall_vdw_retarded_force_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [wvdw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wvdw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic [30:0]                       particle_radius,
    input  logic                              in_group,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                force_dx,
    output logic signed [31:0]                force_dy,
    output logic signed [31:0]                force_dz,
    output logic                              in_range,
    output logic                              saturated
);
    import wvdw_pkg::*;

    // configuration registers
    logic [2:0]         wall_face_reg;
    logic signed [31:0] wall_position_reg;
    logic               radius_mode_reg;
    logic [30:0]        retard_b_reg;
    logic [30:0]        retard_lambda_reg;
    logic [30:0]        min_separation_reg;
    logic [30:0]        hamaker_reg;
    logic [30:0]        cutoff_reg;
    coef_t              coef;

    // front to queue to back
    logic             push;
    work_t            push_item;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;
    work_t            pop_item;

    // back end control, advances as one unit
    logic             back_en;
    logic             mul_valid;
    meta_t            mul_meta;
    logic [NUM_W-1:0] mul_num;
    logic [DEN_W-1:0] mul_den;
    logic             div_valid;
    meta_t            div_meta;
    logic [QUO_W-1:0] div_quo;
    logic             div_big;

    // final shaping of the magnitude
    logic             sat_next;
    logic [31:0]      mag_next;
    logic [31:0]      force_next;
    logic [31:0]      fx_next, fy_next, fz_next;

    // output register
    logic             out_valid_reg;
    logic [31:0]      force_dx_reg, force_dy_reg, force_dz_reg;
    logic             in_range_reg;
    logic             saturated_reg;
    logic             out_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_face_reg      <= '0;
            wall_position_reg  <= '0;
            radius_mode_reg    <= 1'b1;
            retard_b_reg       <= ONE_Q16;
            retard_lambda_reg  <= ONE_Q16;
            min_separation_reg <= ONE_Q16;
            hamaker_reg        <= ONE_Q16;
            cutoff_reg         <= ONE_Q16;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WALL_FACE:      wall_face_reg      <= cfg_data[2:0];
                REG_WALL_POSITION:  wall_position_reg  <= cfg_data;
                REG_RADIUS_MODE:    radius_mode_reg    <= cfg_data[0];
                REG_RETARD_B:       retard_b_reg       <= cfg_data[30:0];
                REG_RETARD_LAMBDA:  retard_lambda_reg  <= cfg_data[30:0];
                REG_MIN_SEPARATION: min_separation_reg <= cfg_data[30:0];
                REG_HAMAKER:        hamaker_reg        <= cfg_data[30:0];
                REG_CUTOFF:         cutoff_reg         <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    assign coef.hamaker = hamaker_reg;
    assign coef.lambda  = retard_lambda_reg;
    assign coef.b       = retard_b_reg;

    // classification front
    wvdw_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .particle_radius (particle_radius),
        .in_group        (in_group),
        .wall_face       (wall_face_reg),
        .wall_position   (wall_position_reg),
        .radius_mode     (radius_mode_reg),
        .min_separation  (min_separation_reg),
        .cutoff          (cutoff_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_item       (push_item)
    );

    wvdw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back end moves whenever the output register can take a result
    assign back_en = !out_valid_reg || !out_stall;
    assign pop     = back_en && !queue_empty;

    wvdw_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (pop),
        .in_item   (pop_item),
        .coef      (coef),
        .out_valid (mul_valid),
        .out_meta  (mul_meta),
        .out_num   (mul_num),
        .out_den   (mul_den)
    );

    wvdw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (mul_valid),
        .in_meta   (mul_meta),
        .in_num    (mul_num),
        .in_den    (mul_den),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .out_quo   (div_quo),
        .out_big   (div_big)
    );

    // lo wall allows a magnitude of 2^31, hi wall 2^31-1
    assign sat_next   = div_meta.side ? (div_big || div_quo[31])
                                      : (div_big || (div_quo > LIMIT_LO));
    assign mag_next   = sat_next ? (div_meta.side ? LIMIT_HI : LIMIT_LO) : div_quo;
    assign force_next = div_meta.side ? mag_next : 32'(-mag_next);

    always_comb
    begin
        fx_next = '0;
        fy_next = '0;
        fz_next = '0;
        if (div_meta.active)
        begin
            case (div_meta.axis)
                AXIS_X:  fx_next = force_next;
                AXIS_Y:  fy_next = force_next;
                AXIS_Z:  fz_next = force_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (back_en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            force_dx_reg  <= fx_next;
            force_dy_reg  <= fy_next;
            force_dz_reg  <= fz_next;
            in_range_reg  <= div_meta.active;
            saturated_reg <= div_meta.active && sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_dx  = force_dx_reg;
    assign force_dy  = force_dy_reg;
    assign force_dz  = force_dz_reg;
    assign in_range  = in_range_reg;
    assign saturated = saturated_reg;

    // an out-of-band result carries nothing
    assign out_zero = (force_dx_reg == '0) && (force_dy_reg == '0)
                   && (force_dz_reg == '0) && !saturated_reg;

    `WVDW_ASSERT_IMPLIES(a_idle_zero, out_valid_reg && !in_range_reg, out_zero)
    `WVDW_ASSERT_IMPLIES(a_sat_in_range, out_valid_reg && saturated_reg, in_range_reg)
    `WVDW_ASSERT_NEVER(a_pop_frozen, pop && !back_en)

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the retarded van der Waals wall force unit
// depends on wvdw_pkg and wall_vdw_retarded_force_unit; drives particles, checks forces
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wvdw_pkg::*;

    // wall face codes, axis times two plus side
    localparam logic [2:0] FACE_XLO  = 3'd0;
    localparam logic [2:0] FACE_XHI  = 3'd1;
    localparam logic [2:0] FACE_YHI  = 3'd3;
    localparam logic [2:0] FACE_ZLO  = 3'd4;
    localparam logic [2:0] FACE_ZHI  = 3'd5;
    localparam logic [2:0] FACE_NONE6 = 3'd6;
    localparam logic [2:0] FACE_NONE7 = 3'd7;

    localparam int NUM_PHASES   = 14;
    localparam int ITEMS_PHASE  = 120;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               hit;
        logic               sat;
    } force_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [30:0]        rad;
        logic               grp;
        bit                 known;
        force_t             res;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [30:0] particle_radius;
    logic in_group;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] force_dx, force_dy, force_dz;
    logic in_range;
    logic saturated;

    wall_vdw_retarded_force_unit uut (.*);

    // testbench copy of the register file
    logic [2:0]         face_r;
    logic signed [31:0] wall_r;
    logic               rmode_r;
    logic [30:0]        b_r, lam_r, smin_r, ham_r, cut_r;

    force_t pending_forces[$];
    int     errors = 0;
    int     transfers_in = 0;
    int     transfers_out = 0;
    int     band_hits = 0;
    int     sat_hits = 0;
    bit     long_hold = 0;

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // exact force prediction for one particle under the current registers
    function automatic force_t wall_force(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz, logic [30:0] rad,
                                          logic grp);
        force_t f;
        logic [1:0] axis;
        longint p, d, absd, size, sep, abssep, s;
        logic [31:0] reff2;
        logic [191:0] num, den, quo, lim;
        bit band;
        f = '0;
        axis = face_r[2:1];
        if (!grp || axis == AXIS_NONE)
            return f;
        p = (axis == AXIS_X) ? longint'(px) : (axis == AXIS_Y) ? longint'(py) : longint'(pz);
        d = face_r[0] ? longint'(wall_r) - p : p - longint'(wall_r);
        absd = d < 0 ? -d : d;
        size = rmode_r ? longint'(rad) : longint'(cut_r);
        reff2 = rmode_r ? {rad, 1'b0} : {1'b0, cut_r};
        sep = absd - size;
        abssep = sep < 0 ? -sep : sep;
        band = rmode_r ? (2 * abssep < size) : (4 * abssep < size);
        if (!band)
            return f;
        s = sep < longint'(smin_r) ? longint'(smin_r) : sep;
        // Ha*2Reff*lambda*2^32 over 12*s^2*(b*s + lambda*2^16)
        num = (192'(ham_r) * 192'(reff2) * 192'(lam_r)) << 32;
        den = 192'd12 * 192'(s) * 192'(s)
              * (192'(b_r) * 192'(s) + (192'(lam_r) << 16));
        lim = face_r[0] ? 192'(LIMIT_HI) : 192'(LIMIT_LO);
        if (den == 0)
            quo = (num == 0) ? 192'd0 : (192'd1 << 33);
        else
            quo = num / den;
        if (quo > lim)
        begin
            quo = lim;
            f.sat = 1'b1;
        end
        f.hit = 1'b1;
        if (face_r[0])
            p = longint'(quo[31:0]);
        else
            p = -longint'(quo[32:0]);
        case (axis)
            AXIS_X: f.fx = p[31:0];
            AXIS_Y: f.fy = p[31:0];
            default: f.fz = p[31:0];
        endcase
        return f;
    endfunction

    // drive one particle and hold it until the transfer happens
    task automatic send_particle(row_t r);
        force_t want;
        in_valid <= 1'b1;
        pos_x <= r.px;
        pos_y <= r.py;
        pos_z <= r.pz;
        particle_radius <= r.rad;
        in_group <= r.grp;
        do
            @(posedge clk);
        while (in_stall);
        want = wall_force(r.px, r.py, r.pz, r.rad, r.grp);
        if (r.known && want != r.res)
            begin
                $error("directed row disagrees with prediction: %h vs %h", r.res, want);
                errors++;
            end
        pending_forces.push_back(r.known ? r.res : want);
        transfers_in++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait until every expected force has come back, then let the pipe settle
    task automatic wait_drained();
        idle_gap(1);
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all eight registers on back-to-back edges
    task automatic load_registers(logic [2:0] face, logic signed [31:0] wall, logic rmode,
                                  logic [30:0] b, logic [30:0] lam, logic [30:0] smin,
                                  logic [30:0] ham, logic [30:0] cut);
        logic [31:0] vals[8];
        vals = '{32'(face), wall, 32'(rmode), 32'(b), 32'(lam), 32'(smin), 32'(ham), 32'(cut)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        face_r = face; wall_r = wall; rmode_r = rmode;
        b_r = b; lam_r = lam; smin_r = smin; ham_r = ham; cut_r = cut;
    endtask

    function automatic logic [30:0] rand_q(int scale);
        case (scale)
            0: return 31'($urandom_range(1, 1 << 18));
            1: return 31'($urandom_range(1, 1 << 24));
            default: return 31'($urandom);
        endcase
    endfunction

    // particle mostly placed inside the band of the current wall
    function automatic row_t rand_particle();
        row_t r;
        longint size, off, coord;
        r.known = 0;
        r.res = '0;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        r.rad = ($urandom_range(0, 9) == 0) ? 31'($urandom) : rand_q($urandom_range(0, 2));
        r.grp = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) != 0)
        begin
            size = rmode_r ? longint'(r.rad) : longint'(cut_r);
            off = (size / (rmode_r ? 2 : 4)) + 1;
            off = longint'($urandom_range(0, 32'(off))) * 2 - off;
            off = size + off;
            if ($urandom_range(0, 1))
                off = -off;
            coord = longint'(wall_r) + off;
            case (face_r[2:1])
                AXIS_X: r.px = coord[31:0];
                AXIS_Y: r.py = coord[31:0];
                default: r.pz = coord[31:0];
            endcase
        end
        return r;
    endfunction

    // receiver: checks each taken force, random stall modes, plus one long hold
    initial
    begin
        int mode;
        int cnt;
        int hold;
        mode = 0;
        cnt = 0;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_forces.size() == 0)
                begin
                    $error("force result with none expected");
                    errors++;
                end
                else
                begin
                    force_t w;
                    w = pending_forces.pop_front();
                    if (force_dx !== w.fx)
                        begin $error("force_dx exp %0d got %0d", w.fx, force_dx); errors++; end
                    if (force_dy !== w.fy)
                        begin $error("force_dy exp %0d got %0d", w.fy, force_dy); errors++; end
                    if (force_dz !== w.fz)
                        begin $error("force_dz exp %0d got %0d", w.fz, force_dz); errors++; end
                    if (in_range !== w.hit)
                        begin $error("in_range exp %0b got %0b", w.hit, in_range); errors++; end
                    if (saturated !== w.sat)
                        begin $error("saturated exp %0b got %0b", w.sat, saturated); errors++; end
                    band_hits += w.hit;
                    sat_hits += w.sat;
                    transfers_out++;
                end
            end
            if (long_hold && hold == 0)
            begin
                hold = 400;
                long_hold = 0;
            end
            cnt++;
            if (cnt % 64 == 0)
                mode = $urandom_range(0, 2);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 9) < mode * 3);
        end
    end

    // stimulus
    initial
    begin
        row_t rows[8];
        int burst;
        logic [2:0] face;
        logic [30:0] b, lam, smin, ham, cut;
        logic signed [31:0] wall;
        logic rmode;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        particle_radius = '0;
        in_group = 1'b0;
        face_r = FACE_XLO; wall_r = 0; rmode_r = 1'b1;
        b_r = ONE_Q16; lam_r = ONE_Q16; smin_r = ONE_Q16; ham_r = ONE_Q16; cut_r = ONE_Q16;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows at the reset settings: x lo wall at zero, radius mode, all 1.0
        rows[0] = '{0, 0, 0, ONE_Q16, 1'b0, 1, '0};
        rows[1] = '{32'sd65536, 0, 0, ONE_Q16, 1'b1, 1, '{-32'sd5461, 0, 0, 1'b1, 1'b0}};
        rows[2] = '{-32'sd65536, 0, 0, ONE_Q16, 1'b1, 1, '{-32'sd5461, 0, 0, 1'b1, 1'b0}};
        rows[3] = '{32'h7FFF_FFFF, 0, 0, 31'd0, 1'b1, 1, '0};
        rows[4] = '{32'sh8000_0000, 32'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b1, 0, '0};
        rows[5] = '{32'h7FFF_FFFF, 32'sh8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 0, '0};
        rows[6] = '{32'sd300000, -32'sd1, 32'sd1, 31'd200000, 1'b1, 0, '0};
        rows[7] = '{32'sd1000000, 0, 0, ONE_Q16, 1'b1, 1, '0};
        foreach (rows[i])
            send_particle(rows[i]);
        wait_drained();

        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            face = 3'($urandom_range(0, 5));
            wall = ($urandom_range(0, 3) == 0) ? $urandom : $signed(32'($urandom_range(0, 1 << 24)))
                   - 32'sd8388608;
            rmode = $urandom_range(0, 1);
            b = rand_q($urandom_range(0, 2)) | 31'd1;
            lam = rand_q($urandom_range(0, 2));
            smin = rand_q($urandom_range(0, 1)) | 31'd1;
            ham = rand_q($urandom_range(0, 2));
            cut = rand_q($urandom_range(0, 1)) | 31'd1;
            // extremes and the special cases on fixed phases
            case (ph)
                1: begin face = FACE_XHI; wall = 32'h7FFF_FFFF; rmode = 1'b0; b = '1; lam = '1;
                        smin = 31'd1; ham = '1; cut = '1; end
                2: face = FACE_NONE6;
                3: face = FACE_NONE7;
                4: begin face = FACE_YHI; b = '0; lam = '0; smin = '0; end
                5: begin face = FACE_ZLO; lam = '0; end
                6: begin face = FACE_ZHI; wall = 32'sh8000_0000; ham = '0; end
                7: begin smin = '1; ham = '1; end
                8: begin b = 31'd1; smin = 31'd1; ham = '1; lam = '1; end
                default: ;
            endcase
            load_registers(face, wall, rmode, b, lam, smin, ham, cut);
            burst = 0;
            for (int k = 0; k < ITEMS_PHASE; k++)
            begin
                if (ph == 3 && k == 20)
                    long_hold = 1;
                // sender waits out every outstanding force once
                if (ph == 5 && k == 60)
                begin
                    idle_gap(1);
                    while (pending_forces.size() != 0)
                        @(posedge clk);
                end
                if (burst == 0)
                begin
                    idle_gap((ph == 3) ? 0 : $urandom_range(0, 8));
                    burst = $urandom_range(1, 30);
                end
                burst--;
                send_particle(rand_particle());
            end
            wait_drained();
        end

        $display("tb_top: %0d particles sent, %0d forces checked", transfers_in, transfers_out);
        $display("tb_top: %0d in band, %0d saturated, %0d setting phases",
                 band_hits, sat_hits, NUM_PHASES + 1);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/wvdw_pkg.sv
hdl/wvdw_front.sv
hdl/wvdw_fifo.sv
hdl/wvdw_mul.sv
hdl/wvdw_div.sv
hdl/wall_vdw_retarded_force_unit.sv
tb/tb_top.sv
